/* rtl/wsq_pkg.sv */
// Shared types and constants for the weighted semaphore wait queue.
// It has no dependencies. The cell chain, the top level and the checker use it.
package wsq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int TOKEN_W     = 32;
  localparam int NEED_W      = 16;
  localparam int TID_W       = 8;

  typedef enum logic [1:0] {
    MODE_WAIT   = 2'd0,
    MODE_SIGNAL = 2'd1,
    MODE_CLOSE  = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_CLOSED   = 3'd2,
    ST_FULL     = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic {
    KIND_DONE    = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_ROTATE,
    CELL_APPEND
  } cell_op_t;

  typedef struct packed {
    logic [TID_W-1:0]  tid;
    logic [NEED_W-1:0] need;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   load;
  } cell_ctl_t;

endpackage

/* rtl/wsq_cell.sv */
// One waiter slot of the queue chain.
// It depends on wsq_pkg for the entry and control types.
module wsq_cell (
  input  logic               clk,
  input  wsq_pkg::cell_ctl_t ctl,
  input  logic               tail_sel,
  input  logic               slot_sel,
  input  wsq_pkg::entry_t    nbr,
  input  wsq_pkg::entry_t    head,
  output wsq_pkg::entry_t    ent
);

  wsq_pkg::entry_t ent_next;

  always_comb begin
    case (ctl.op)
      wsq_pkg::CELL_HOLD:   ent_next = ent;
      wsq_pkg::CELL_SHIFT:  ent_next = nbr;
      wsq_pkg::CELL_ROTATE: ent_next = tail_sel ? head : nbr;
      wsq_pkg::CELL_APPEND: ent_next = slot_sel ? ctl.load : ent;
      default:              ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

/* rtl/weighted_semaphore_wait_queue_unit.sv */
// Top level of the weighted semaphore: token counter, control sequencer and output register.
// It depends on wsq_pkg and instantiates a chain of wsq_cell slots.
//
//   Channel   Handshake                 Payload
//   config    cfg_wr_en                 cfg_wr_data
//   request   in_valid / in_ready       mode, token_count, thread_id
//   result    out_valid / out_ready     result_kind, released_thread, status,
//                                       tokens_left, last
//
// A request is taken only while the sequencer is idle. A wait, a query or a rejected signal
// is decided in the execute state, and its result is registered there once the output
// register is free. A signal then scans the cell chain, releasing each waiter whose need
// fits and rotating the others; a close releases every waiter, then gives its last result.
// A low out_ready that holds the output register stalls the sequencer.
// Reset is synchronous and clears the queue, the closed flag and the token counter.
module weighted_semaphore_wait_queue_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [wsq_pkg::TOKEN_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   mode,
  input  logic [wsq_pkg::NEED_W-1:0]   token_count,
  input  logic [wsq_pkg::TID_W-1:0]    thread_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         result_kind,
  output logic [wsq_pkg::TID_W-1:0]    released_thread,
  output logic [2:0]                   status,
  output logic [wsq_pkg::TOKEN_W-1:0]  tokens_left,
  output logic                         last
);

  localparam int DEPTH = wsq_pkg::QUEUE_DEPTH;
  localparam int CW    = wsq_pkg::COUNT_W;
  localparam int TW    = wsq_pkg::TOKEN_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t                        state, state_next;
  logic [TW-1:0]                 tokens, tokens_next;
  logic [CW-1:0]                 wcount, wcount_next;
  logic [CW-1:0]                 scan, scan_next;
  logic                          closed, closed_next;
  logic [1:0]                    req_mode;
  logic [wsq_pkg::NEED_W-1:0]    req_count;
  logic [wsq_pkg::TID_W-1:0]     req_tid;

  logic                          emit_ok;
  logic                          emit;
  wsq_pkg::kind_t                e_kind;
  logic [wsq_pkg::TID_W-1:0]     e_tid;
  wsq_pkg::status_t              e_status;
  logic [TW-1:0]                 e_tokens;
  logic                          e_last;

  logic [TW:0]                   sum;
  logic                          fits;
  wsq_pkg::cell_ctl_t            ctl;
  wsq_pkg::entry_t               ent [DEPTH];
  logic [DEPTH-1:0]              tail_sel;
  logic [DEPTH-1:0]              slot_sel;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    wsq_pkg::entry_t nbr;
    assign tail_sel[i] = (wcount == CW'(i + 1));
    assign slot_sel[i] = (wcount == CW'(i));
    if (i == DEPTH - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = ent[i+1];
    end
    wsq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .tail_sel (tail_sel[i]),
      .slot_sel (slot_sel[i]),
      .nbr      (nbr),
      .head     (ent[0]),
      .ent      (ent[i])
    );
  end

  assign in_ready = (state == S_IDLE);
  assign emit_ok  = !out_valid || out_ready;
  assign sum      = {1'b0, tokens} + {{(TW + 1 - wsq_pkg::NEED_W){1'b0}}, req_count};
  assign fits     = {{(TW - wsq_pkg::NEED_W){1'b0}}, ent[0].need} <= tokens;

  always_comb begin
    state_next  = state;
    tokens_next = tokens;
    wcount_next = wcount;
    scan_next   = scan;
    closed_next = closed;
    emit        = 1'b0;
    e_kind      = wsq_pkg::KIND_DONE;
    e_tid       = '0;
    e_status    = wsq_pkg::ST_OK;
    e_tokens    = tokens;
    e_last      = 1'b1;
    ctl.op      = wsq_pkg::CELL_HOLD;
    ctl.load    = '{tid: req_tid, need: req_count};
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (req_mode)
          wsq_pkg::MODE_WAIT: begin
            if (emit_ok) begin
              emit       = 1'b1;
              state_next = S_IDLE;
              if (closed) begin
                e_status = wsq_pkg::ST_CLOSED;
              end else if (tokens >= TW'(req_count)) begin
                tokens_next = tokens - TW'(req_count);
                e_tokens    = tokens_next;
              end else if (wcount >= CW'(DEPTH)) begin
                e_status = wsq_pkg::ST_FULL;
              end else begin
                ctl.op      = wsq_pkg::CELL_APPEND;
                wcount_next = wcount + CW'(1);
                e_status    = wsq_pkg::ST_BLOCKED;
              end
            end
          end
          wsq_pkg::MODE_SIGNAL: begin
            if (closed || sum[TW]) begin
              if (emit_ok) begin
                emit       = 1'b1;
                e_status   = closed ? wsq_pkg::ST_CLOSED : wsq_pkg::ST_OVERFLOW;
                state_next = S_IDLE;
              end
            end else begin
              tokens_next = sum[TW-1:0];
              scan_next   = '0;
              state_next  = S_SCAN;
            end
          end
          wsq_pkg::MODE_CLOSE: begin
            closed_next = 1'b1;
            state_next  = S_FLUSH;
          end
          default: begin
            if (emit_ok) begin
              emit       = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (wcount == '0 || scan == wcount) begin
          if (emit_ok) begin
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        end else if (fits) begin
          if (emit_ok) begin
            ctl.op      = wsq_pkg::CELL_SHIFT;
            wcount_next = wcount - CW'(1);
            tokens_next = tokens - TW'(ent[0].need);
            scan_next   = '0;
            emit        = 1'b1;
            e_kind      = wsq_pkg::KIND_RELEASE;
            e_tid       = ent[0].tid;
            e_tokens    = tokens_next;
            e_last      = 1'b0;
          end
        end else begin
          ctl.op    = wsq_pkg::CELL_ROTATE;
          scan_next = scan + CW'(1);
        end
      end
      S_FLUSH: begin
        if (emit_ok) begin
          emit = 1'b1;
          if (wcount == '0) begin
            state_next = S_IDLE;
          end else begin
            ctl.op      = wsq_pkg::CELL_SHIFT;
            wcount_next = wcount - CW'(1);
            e_kind      = wsq_pkg::KIND_RELEASE;
            e_tid       = ent[0].tid;
            e_status    = wsq_pkg::ST_CLOSED;
            e_last      = 1'b0;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tokens    <= '0;
      wcount    <= '0;
      scan      <= '0;
      closed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      wcount <= wcount_next;
      scan   <= scan_next;
      closed <= closed_next;
      if (cfg_wr_en) begin
        tokens <= cfg_wr_data;
      end else begin
        tokens <= tokens_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (emit) begin
      result_kind     <= e_kind;
      released_thread <= e_tid;
      status          <= e_status;
      tokens_left     <= e_tokens;
      last            <= e_last;
    end
    if (in_valid && in_ready) begin
      req_mode  <= mode;
      req_count <= token_count;
      req_tid   <= thread_id;
    end
  end

endmodule

/* rtl/wsq_checker.sv */
// Port-level assertions for the weighted semaphore wait queue, bound to the top level.
// It depends on wsq_pkg for the result kind and status codes.
module wsq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         result_kind,
  input logic [wsq_pkg::TID_W-1:0]    released_thread,
  input logic [2:0]                   status,
  input logic [wsq_pkg::TOKEN_W-1:0]  tokens_left,
  input logic                         last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(status)
      && $stable(released_thread) && $stable(tokens_left) && $stable(last))
    else $error("Result changed while stalled.");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("A second request was taken while one is in progress.");

  a_done_tid: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == wsq_pkg::KIND_DONE |-> released_thread == '0 && last)
    else $error("Completion carries a thread id or is not the last result.");

  a_release_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == wsq_pkg::KIND_RELEASE |-> !last)
    else $error("A release was marked as the last result.");

  a_release_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == wsq_pkg::KIND_RELEASE |->
      status == wsq_pkg::ST_OK || status == wsq_pkg::ST_CLOSED)
    else $error("A release carries an invalid status.");

endmodule

bind weighted_semaphore_wait_queue_unit wsq_checker u_wsq_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .result_kind     (result_kind),
  .released_thread (released_thread),
  .status          (status),
  .tokens_left     (tokens_left),
  .last            (last)
);
